// ===== hdl/eehr_pkg.sv =====
// Package: constants, payload types, command/status structs and helpers for the history ring.
package eehr_pkg;

   localparam int RING_DEPTH = 32;
   localparam int BUCKETS    = 256;

   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int BUCKET_W   = $clog2(BUCKETS);
   localparam int ADDR_W     = 32;
   localparam int TICK_W     = 32;
   localparam int EXPIRY_W   = 31;
   localparam int CNT_W      = 5;
   localparam int ENTRY_W    = TICK_W + ADDR_W;
   localparam int SLOT_W     = BUCKET_W + PTR_W;
   localparam int SLOTS      = BUCKETS * RING_DEPTH;
   localparam int CNT_MAX    = (RING_DEPTH - 1 > 31) ? 31 : RING_DEPTH - 1;

   localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = EXPIRY_W'(75000);

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [7:0]          bucket;
      logic [ADDR_W-1:0]   address;
      logic [TICK_W-1:0]   now;
   } req_type;

   typedef struct packed {
      logic               found;
      logic               overrun;
      logic [CNT_W-1:0]   live_count;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic load_ptr;
      logic drop;
      logic scan;
      logic hit;
      logic record;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic at_tail;
      logic expired;
      logic match;
      logic is_record;
      logic out_free;
   } status_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] ring_count(input logic [PTR_W-1:0] head,
                                                   input logic [PTR_W-1:0] tail);
      logic [PTR_W:0] d;
      d = {1'b0, tail} - {1'b0, head};
      if (tail < head) begin
         d = d + (PTR_W+1)'(RING_DEPTH);
      end
      if (d > (PTR_W+1)'(CNT_MAX)) begin
         d = (PTR_W+1)'(CNT_MAX);
      end
      return CNT_W'(d);
   endfunction

endpackage

// ===== hdl/eehr_ifs.sv =====
// Interfaces: request, response and configuration write channels.
interface eehr_req_if;
   import eehr_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [7:0]          bucket;
   logic [ADDR_W-1:0]   address;
   logic [TICK_W-1:0]   now;
   modport source (output valid, kind, bucket, address, now, input ready);
   modport sink   (input valid, kind, bucket, address, now, output ready);
endinterface

interface eehr_rsp_if;
   import eehr_pkg::*;
   logic               valid;
   logic               ready;
   logic               found;
   logic               overrun;
   logic [CNT_W-1:0]   live_count;
   modport source (output valid, found, overrun, live_count, input ready);
   modport sink   (input valid, found, overrun, live_count, output ready);
endinterface

interface eehr_csr_if;
   import eehr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [EXPIRY_W-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/eehr_ctrl.sv =====
// Controller: sequences pointer load, expiry drop, lookup scan, record and response.
module eehr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  eehr_pkg::status_type   status,
   output eehr_pkg::cmd_type      cmd,
   output logic                   req_ready
);
   import eehr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_EXPIRE = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_RECORD = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_ptr = 1'b1;
            state_in     = ST_EXPIRE;
         end
         ST_EXPIRE: begin
            if (!status.at_tail && status.expired) begin
               cmd.drop = 1'b1;
            end else if (status.is_record) begin
               state_in = ST_RECORD;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.at_tail) begin
               state_in = ST_FINISH;
            end else if (status.match) begin
               cmd.hit  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_RECORD: begin
            cmd.record = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/eehr_dp.sv =====
// Datapath: entry and pointer memories, ring walk, expiry compare, record and response register.
module eehr_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  eehr_pkg::cmd_type               cmd,
   input  eehr_pkg::req_type               req_data,
   input  logic                            csr_we,
   input  logic [eehr_pkg::EXPIRY_W-1:0]   csr_data,
   input  logic                            rsp_ready,
   output eehr_pkg::status_type            status,
   output logic                            rsp_valid,
   output eehr_pkg::rsp_type               rsp_data
);
   import eehr_pkg::*;

   logic [ENTRY_W-1:0]     entry_mem [SLOTS];
   logic [2*PTR_W-1:0]     ptr_mem   [BUCKETS];

   logic [BUCKETS-1:0]     ptr_vld_ff;
   logic [EXPIRY_W-1:0]    expiry_ff;
   logic                   kind_ff;
   logic [BUCKET_W-1:0]    bucket_ff;
   logic [BUCKET_W-1:0]    bucket_in;
   logic [ADDR_W-1:0]      addr_ff;
   logic [TICK_W-1:0]      now_ff;
   logic [2*PTR_W-1:0]     ptr_q_ff;
   logic                   ptr_hit_ff;
   logic [PTR_W-1:0]       head_ff;
   logic [PTR_W-1:0]       tail_ff;
   logic [PTR_W-1:0]       idx_ff;
   logic [PTR_W-1:0]       idx_in;
   logic [ENTRY_W-1:0]     entry_q_ff;
   logic                   found_ff;
   logic                   overrun_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [PTR_W-1:0]       load_head;
   logic [PTR_W-1:0]       load_tail;
   logic [PTR_W-1:0]       tail_next;
   logic [TICK_W-1:0]      age;
   logic [TICK_W-1:0]      new_expiry;

   assign bucket_in = cmd.accept ? req_data.bucket[BUCKET_W-1:0] : bucket_ff;
   assign load_head = ptr_hit_ff ? ptr_q_ff[2*PTR_W-1:PTR_W] : '0;
   assign load_tail = ptr_hit_ff ? ptr_q_ff[PTR_W-1:0] : '0;
   assign tail_next = ring_next(tail_ff);
   assign age        = now_ff - entry_q_ff[ENTRY_W-1:ADDR_W];
   assign new_expiry = now_ff + {1'b0, expiry_ff};

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_ptr) begin
         idx_in = load_head;
      end else if (cmd.drop || cmd.scan) begin
         idx_in = ring_next(idx_ff);
      end
   end

   assign status.at_tail   = (idx_ff == tail_ff);
   assign status.expired   = (age != '0) && !age[TICK_W-1];
   assign status.match     = (entry_q_ff[ADDR_W-1:0] == addr_ff);
   assign status.is_record = (kind_ff == KIND_RECORD);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      entry_q_ff <= entry_mem[{bucket_in, idx_in}];
      if (cmd.record) begin
         entry_mem[{bucket_ff, tail_ff}] <= {new_expiry, addr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ptr_q_ff <= ptr_mem[req_data.bucket[BUCKET_W-1:0]];
      end
      if (cmd.finish) begin
         ptr_mem[bucket_ff] <= {head_ff, tail_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_vld_ff   <= '0;
         expiry_ff    <= EXPIRY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            expiry_ff <= csr_data;
         end
         if (cmd.finish) begin
            ptr_vld_ff[bucket_ff] <= 1'b1;
            rsp_valid_ff          <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.accept) begin
         kind_ff    <= req_data.kind;
         bucket_ff  <= req_data.bucket[BUCKET_W-1:0];
         addr_ff    <= req_data.address;
         now_ff     <= req_data.now;
         ptr_hit_ff <= ptr_vld_ff[req_data.bucket[BUCKET_W-1:0]];
         found_ff   <= 1'b0;
         overrun_ff <= 1'b0;
      end
      if (cmd.load_ptr) begin
         head_ff <= load_head;
         tail_ff <= load_tail;
      end
      if (cmd.drop) begin
         head_ff <= ring_next(idx_ff);
      end
      if (cmd.hit) begin
         found_ff <= 1'b1;
      end
      if (cmd.record) begin
         tail_ff <= tail_next;
         if (tail_next == head_ff) begin
            head_ff    <= ring_next(head_ff);
            overrun_ff <= 1'b1;
         end
      end
      if (cmd.finish) begin
         rsp_ff.found      <= found_ff;
         rsp_ff.overrun    <= overrun_ff;
         rsp_ff.live_count <= ring_count(head_ff, tail_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/expiring_eviction_history_ring_unit.sv =====
// Top level: per-bucket expiring eviction history rings with lookup and record.
//
//  channel  dir  carries                              transaction when
//  req_ch   in   kind, bucket, address, now           valid && ready
//  rsp_ch   out  found, overrun, live_count           valid && ready
//  csr_ch   in   expiry_ticks write data              valid && ready (ready tied high)
//
// One request at a time: accept, pointer load, then a walk over the ring entries
// (expired entries dropped, then matched on lookup; at most 31 in total), then
// expiry exit, record or scan exit and response load; the single-read-port entry
// memory is walked one slot per cycle.
// Reset is synchronous; ring pointers read as empty until a bucket is first used.
// A stalled response holds the finished transaction; a new request is accepted
// meanwhile, and its response load waits until the response register frees.
module expiring_eviction_history_ring_unit (
   input  logic          clock,
   input  logic          reset,
   eehr_req_if.sink      req_ch,
   eehr_rsp_if.source    rsp_ch,
   eehr_csr_if.sink      csr_ch
);
   import eehr_pkg::*;

   cmd_type      cmd;
   status_type   status;
   req_type      req_data;
   rsp_type      rsp_data;
   logic         req_ready;
   logic         rsp_valid;

   assign req_data.kind    = req_ch.kind;
   assign req_data.bucket  = req_ch.bucket;
   assign req_data.address = req_ch.address;
   assign req_data.now     = req_ch.now;
   assign req_ch.ready     = req_ready;
   assign csr_ch.ready     = 1'b1;

   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.found      = rsp_data.found;
   assign rsp_ch.overrun    = rsp_data.overrun;
   assign rsp_ch.live_count = rsp_data.live_count;

   eehr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   eehr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_ch.valid),
      .csr_data  (csr_ch.data),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while controller busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.live_count <= CNT_W'(CNT_MAX))
      else $error("live count beyond ring capacity");

   a_overrun_full: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.overrun |-> rsp_ch.live_count == CNT_W'(CNT_MAX))
      else $error("overrun reported on a ring that is not full");

   a_overrun_no_found: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.overrun |-> !rsp_ch.found)
      else $error("record transaction reported a lookup hit");

endmodule

// ===== tb/sv/eehr_history_checker.sv =====
// Checker: watches the channels, predicts each history ring result and compares it.
module eehr_history_checker
   import eehr_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   eehr_req_if    req_ch,
   eehr_rsp_if    rsp_ch,
   eehr_csr_if    csr_ch,
   output int     mismatch_count,
   output int     pending_count,
   output int     hit_count,
   output int     overrun_count
);

   logic [ADDR_W-1:0]     hist_addr   [SLOTS];
   logic [TICK_W-1:0]     hist_expiry [SLOTS];
   logic [PTR_W-1:0]      oldest_ptr  [BUCKETS];
   logic [PTR_W-1:0]      free_ptr    [BUCKETS];
   logic [EXPIRY_W-1:0]   expiry_ticks;
   rsp_type               expected_results [$];
   int                    errors   = 0;
   int                    hits     = 0;
   int                    overruns = 0;

   // wrap-safe "now is past expiry"
   function automatic logic is_stale(input logic [TICK_W-1:0] now,
                                     input logic [TICK_W-1:0] expiry);
      logic [TICK_W-1:0] d;
      d = now - expiry;
      return (d != '0) && !d[TICK_W-1];
   endfunction

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return PTR_W'((int'(p) + 1) % RING_DEPTH);
   endfunction

   function automatic rsp_type predict_history(input req_type r);
      rsp_type            res;
      int                 b;
      int                 base;
      int                 count;
      logic [PTR_W-1:0]   head;
      logic [PTR_W-1:0]   tail;
      logic [PTR_W-1:0]   i;
      res  = '0;
      b    = int'(r.bucket) % BUCKETS;
      base = b * RING_DEPTH;
      head = oldest_ptr[b];
      tail = free_ptr[b];
      while (head != tail && is_stale(r.now, hist_expiry[base + int'(head)])) begin
         head = advance(head);
      end
      if (r.kind == KIND_LOOKUP) begin
         for (i = head; i != tail; i = advance(i)) begin
            if (hist_addr[base + int'(i)] == r.address) begin
               res.found = 1'b1;
            end
         end
      end else begin
         hist_addr[base + int'(tail)]   = r.address;
         hist_expiry[base + int'(tail)] = r.now + TICK_W'(expiry_ticks);
         tail = advance(tail);
         if (tail == head) begin
            head        = advance(head);
            res.overrun = 1'b1;
         end
      end
      oldest_ptr[b] = head;
      free_ptr[b]   = tail;
      count = (int'(tail) + RING_DEPTH - int'(head)) % RING_DEPTH;
      if (count > 31) begin
         count = 31;
      end
      res.live_count = CNT_W'(count);
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      req_type   r;
      rsp_type   want;
      rsp_type   got;
      if (reset) begin
         for (int b = 0; b < BUCKETS; b++) begin
            oldest_ptr[b] = '0;
            free_ptr[b]   = '0;
         end
         expiry_ticks = EXPIRY_RESET;
         expected_results.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            expiry_ticks = csr_ch.data;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.found      = rsp_ch.found;
            got.overrun    = rsp_ch.overrun;
            got.live_count = rsp_ch.live_count;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction: expected none, actual found %0d overrun %0d live_count %0d",
                        $time, got.found, got.overrun, got.live_count);
               errors++;
            end else begin
               want = expected_results.pop_front();
               check_field("found", want.found, got.found);
               check_field("overrun", want.overrun, got.overrun);
               check_field("live_count", want.live_count, got.live_count);
               hits     += want.found;
               overruns += want.overrun;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            r.kind    = req_ch.kind;
            r.bucket  = req_ch.bucket;
            r.address = req_ch.address;
            r.now     = req_ch.now;
            expected_results.push_back(predict_history(r));
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_results.size();
      hit_count      <= hits;
      overrun_count  <= overruns;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: clock, reset, request and configuration stimulus, and the verdict.
module tb_top;
   import eehr_pkg::*;

   localparam int ITEMS_PER_PHASE = 180;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 40;
   localparam logic [TICK_W-1:0] WRAP_BASE = 32'hFFFF_FFF0;

   logic                clock = 1'b0;
   logic                reset;
   int                  mismatch_count;
   int                  pending_count;
   int                  hit_count;
   int                  overrun_count;
   int                  cycle_count = 0;
   int                  requests_sent = 0;
   int                  settings_written = 0;
   logic                calm = 1'b0;
   logic [TICK_W-1:0]   tick;
   logic [ADDR_W-1:0]   addr_pool [16];
   logic [7:0]          hot [4];

   eehr_req_if req_ch ();
   eehr_rsp_if rsp_ch ();
   eehr_csr_if csr_ch ();

   expiring_eviction_history_ring_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .csr_ch  (csr_ch)
   );

   eehr_history_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .hit_count      (hit_count),
      .overrun_count  (overrun_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int draw_run();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(150, 400);
      end
      return $urandom_range(1, 16);
   endfunction

   initial begin : rsp_stall
      int left;
      int gap;
      left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (left > 0) begin
            left--;
         end else if (rsp_ch.ready) begin
            gap = draw_gap();
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               left = gap - 1;
            end else begin
               left = draw_run();
            end
         end else begin
            rsp_ch.ready <= 1'b1;
            left = draw_run();
         end
      end
   end

   task automatic send_request(input logic kind, input logic [7:0] bucket,
                               input logic [ADDR_W-1:0] address, input logic [TICK_W-1:0] now);
      int gap;
      gap = calm ? 0 : draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.bucket  <= bucket;
      req_ch.address <= address;
      req_ch.now     <= now;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      requests_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_expiry(input logic [EXPIRY_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      settings_written++;
   endtask

   // bursts aimed at one bucket: fill, probe or mixed, with some noise
   task automatic run_phase(input int items, input logic [EXPIRY_W-1:0] expiry);
      int                  done;
      int                  burst_len;
      int                  style;
      int                  step_max;
      int                  step;
      logic                kind;
      logic                noise;
      logic [7:0]          bucket;
      logic [7:0]          b;
      logic [ADDR_W-1:0]   address;
      logic [TICK_W-1:0]   now;
      done     = 0;
      step_max = int'(expiry) / 24 + 2;
      hot[2]   = 8'($urandom_range(1, 254));
      hot[3]   = 8'($urandom_range(1, 254));
      while (done < items) begin
         bucket    = ($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, 3)]
                                                  : 8'($urandom_range(0, 255));
         burst_len = $urandom_range(1, 40);
         style     = $urandom_range(0, 2);
         calm      = ($urandom_range(0, 5) == 0);
         for (int k = 0; k < burst_len && done < items; k++) begin
            noise = ($urandom_range(0, 15) == 0);
            case (style)
               0: kind = ($urandom_range(0, 9) != 0) ? KIND_RECORD : KIND_LOOKUP;
               1: kind = ($urandom_range(0, 9) == 0) ? KIND_RECORD : KIND_LOOKUP;
               default: kind = $urandom_range(0, 1) ? KIND_RECORD : KIND_LOOKUP;
            endcase
            address = (noise || $urandom_range(0, 7) == 0) ? ADDR_W'($urandom)
                                                           : addr_pool[$urandom_range(0, 15)];
            step = (style == 0) ? $urandom_range(0, step_max / 4) : $urandom_range(0, step_max);
            tick = tick + TICK_W'(step);
            now  = (noise && $urandom_range(0, 1)) ? TICK_W'($urandom) : tick;
            b    = noise ? 8'($urandom_range(0, 255)) : bucket;
            send_request(kind, b, address, now);
            done++;
         end
      end
      calm = 1'b0;
   endtask

   initial begin : stimulus
      logic [EXPIRY_W-1:0]   expiry_plan [5];
      logic [TICK_W-1:0]     e255;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.kind    <= KIND_LOOKUP;
      req_ch.bucket  <= '0;
      req_ch.address <= '0;
      req_ch.now     <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.data    <= '0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < 16; i++) begin
         addr_pool[i] = ADDR_W'($urandom);
      end
      hot[0] = 8'd0;
      hot[1] = 8'd255;
      expiry_plan[0] = '0;
      expiry_plan[1] = EXPIRY_W'(1);
      expiry_plan[2] = '1;
      expiry_plan[3] = EXPIRY_W'(300);
      expiry_plan[4] = EXPIRY_W'($urandom_range(2, 1_000_000));
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset expiry; wrap of now and expiry, exact-expiry and half-range boundaries
      e255 = 32'hFFFF_FFFF + TICK_W'(EXPIRY_RESET);
      send_request(KIND_LOOKUP, 8'd0, 32'h0000_0000, WRAP_BASE);
      send_request(KIND_RECORD, 8'd0, 32'h0000_0000, WRAP_BASE);
      send_request(KIND_RECORD, 8'd0, 32'hFFFF_FFFF, WRAP_BASE + 32'd5);
      send_request(KIND_LOOKUP, 8'd0, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(KIND_LOOKUP, 8'd0, 32'h0000_0000, WRAP_BASE + TICK_W'(EXPIRY_RESET));
      send_request(KIND_LOOKUP, 8'd0, 32'h0000_0000, WRAP_BASE + TICK_W'(EXPIRY_RESET) + 32'd1);
      send_request(KIND_RECORD, 8'd255, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
      send_request(KIND_LOOKUP, 8'd255, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
      send_request(KIND_LOOKUP, 8'd255, 32'hA5A5_A5A5, e255 + 32'h8000_0000);
      send_request(KIND_LOOKUP, 8'd255, 32'hA5A5_A5A5, e255 + 32'h7FFF_FFFF);

      tick = 32'hFFF0_0000;
      run_phase(ITEMS_PER_PHASE, EXPIRY_RESET);

      for (int p = 0; p < 5; p++) begin
         drain_results();
         write_expiry(expiry_plan[p]);
         if (expiry_plan[p] == '0) begin
            // zero expiry: live at the recording tick only
            send_request(KIND_RECORD, 8'd1, 32'h1234_5678, 32'd1000);
            send_request(KIND_LOOKUP, 8'd1, 32'h1234_5678, 32'd1000);
            send_request(KIND_LOOKUP, 8'd1, 32'h1234_5678, 32'd1001);
         end
         run_phase(ITEMS_PER_PHASE, expiry_plan[p]);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_count != 0) begin
         $display("%0d expected results never arrived", pending_count);
      end
      $display("Ran %0d lookup/record transactions under %0d expiry settings (%0d writes).",
               requests_sent, settings_written + 1, settings_written);
      $display("Saw %0d lookup hits and %0d ring overruns; %0d mismatches.",
               hit_count, overrun_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
